>>> rtl/core/egcd_pkg.sv
// Shared constants, types and state encoding for the Euclidean GCD block.
`timescale 1ns / 1ps

package egcd_pkg;

    // Operand and result width in bits.
    localparam int OPERAND_WIDTH = 32;

    // Width of the divider step counter and the index of its last step.
    localparam int CNT_W = $clog2(OPERAND_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OPERAND_WIDTH - 1);

    typedef logic [OPERAND_WIDTH-1:0] word_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_UPDATE,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
        logic capture;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic b_zero;
    } status_t;

endpackage

>>> rtl/core/euclid_gcd.sv
// Top level of the Euclidean greatest common divisor block.
`timescale 1ns / 1ps

//  Channel   Signals                                  Direction  Meaning
//  input     in_valid, in_stall, first_value,         in         one item: two signed operands
//            second_value
//  output    out_valid, out_stall, divisor            out        one item: the signed gcd
//
//  An item of operands a and b runs (a, b) <- (b, a rem b) until b is zero, with the
//  remainder truncating toward zero, and returns the final a. Each Euclid step is a zero
//  test, one quotient bit per cycle in the serial restoring divider, and an update of the
//  operand pair. Reset is asynchronous and clears the controller and the result valid
//  flag only. The block takes one item at a time; it accepts the next item while its
//  result still waits under out_stall, and holds a finished result in the done state
//  until the result register is free.
module euclid_gcd
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [egcd_pkg::OPERAND_WIDTH-1:0] first_value,
    input  logic signed [egcd_pkg::OPERAND_WIDTH-1:0] second_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [egcd_pkg::OPERAND_WIDTH-1:0] divisor
);

    egcd_pkg::cmd_t    cmd;
    egcd_pkg::status_t status;
    egcd_pkg::word_t   divisor_word;

    // Sequencing of the steps and both handshakes.
    egcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Operand pair, divider and the result register.
    egcd_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .first_value  (egcd_pkg::word_t'(first_value)),
        .second_value (egcd_pkg::word_t'(second_value)),
        .status       (status),
        .divisor      (divisor_word)
    );

    assign divisor = $signed(divisor_word);

endmodule

>>> rtl/core/egcd_dp.sv
// Datapath: operand registers, serial restoring divider and result register.
`timescale 1ns / 1ps

module egcd_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  egcd_pkg::cmd_t        cmd,
    input  egcd_pkg::word_t       first_value,
    input  egcd_pkg::word_t       second_value,
    output egcd_pkg::status_t     status,
    output egcd_pkg::word_t       divisor
);

    localparam int W = egcd_pkg::OPERAND_WIDTH;

    logic [W-1:0] a_reg,       a_next;
    logic [W-1:0] b_reg,       b_next;
    logic [W-1:0] mb_reg,      mb_next;
    logic [W-1:0] dvd_reg,     dvd_next;
    logic [W-1:0] rem_reg,     rem_next;
    logic         neg_reg,     neg_next;
    logic [W-1:0] divisor_reg, divisor_next;

    logic [W:0]   trial;
    logic [W:0]   diff;

    // One restoring division step: bring down the next dividend bit and
    // subtract the divisor magnitude when it fits.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        diff  = trial - {1'b0, mb_reg};
    end

    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        mb_next      = mb_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        divisor_next = divisor_reg;

        if (cmd.load)
        begin
            a_next = first_value;
            b_next = second_value;
        end

        if (cmd.div_start)
        begin
            neg_next = a_reg[W-1];
            dvd_next = a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
            mb_next  = b_reg[W-1] ? (W'(0) - b_reg) : b_reg;
            rem_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
        end

        // The remainder takes the sign of the dividend.
        if (cmd.update)
        begin
            a_next = b_reg;
            b_next = neg_reg ? (W'(0) - rem_reg) : rem_reg;
        end

        if (cmd.capture)
        begin
            divisor_next = a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        mb_reg      <= mb_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        divisor_reg <= divisor_next;
    end

    assign status.b_zero = (b_reg == '0);
    assign divisor       = divisor_reg;

    // The finished remainder magnitude is always below the divisor magnitude.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (rem_reg < mb_reg))
        else $error("remainder not below divisor at update");

    // A division is only started with a nonzero divisor.
    a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.b_zero)
        else $error("division started with zero divisor");

    // Every divider step works against a nonzero divisor magnitude.
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (mb_reg != '0))
        else $error("divider step with zero divisor magnitude");

endmodule

>>> rtl/core/egcd_ctrl.sv
// Controller: sequences Euclid steps and the serial divider, owns the handshakes.
`timescale 1ns / 1ps

module egcd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  egcd_pkg::status_t     status,
    output egcd_pkg::cmd_t        cmd
);

    egcd_pkg::state_t               state_reg, state_next;
    logic [egcd_pkg::CNT_W-1:0]     cnt_reg,   cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            egcd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = egcd_pkg::S_TEST;
                end
            end
            egcd_pkg::S_TEST:
            begin
                state_next = status.b_zero ? egcd_pkg::S_DONE : egcd_pkg::S_DIV;
            end
            egcd_pkg::S_DIV:
            begin
                if (cnt_reg == egcd_pkg::LAST_STEP)
                begin
                    state_next = egcd_pkg::S_UPDATE;
                end
            end
            egcd_pkg::S_UPDATE:
            begin
                state_next = egcd_pkg::S_TEST;
            end
            egcd_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = egcd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = egcd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        cnt_next = cnt_reg;
        unique case (state_reg)
            egcd_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            egcd_pkg::S_TEST:
            begin
                cmd.div_start = !status.b_zero;
                cnt_next      = '0;
            end
            egcd_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            egcd_pkg::S_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            egcd_pkg::S_DONE:
            begin
                cmd.capture = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= egcd_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted item always starts with a zero test of the second operand.
    a_accept_to_test: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == egcd_pkg::S_TEST))
        else $error("accepted item did not enter the test state");

    // The result register is never overwritten while a result waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    // A new result only appears on leaving the done state.
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == egcd_pkg::S_DONE))
        else $error("result raised outside the done state");

    // The update follows a full run of divider steps.
    a_update_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == egcd_pkg::S_UPDATE) |->
            ($past(state_reg) == egcd_pkg::S_DIV &&
             $past(cnt_reg) == egcd_pkg::LAST_STEP))
        else $error("update without a complete division");

endmodule
